// ===== hdl/earic_pkg.sv =====
// Shared types and constants for the Ethernet ARP/IPv4/ICMP receive classifier.
package earic_pkg;

  localparam int MaxFrameDefault = 1514;
  localparam logic [31:0] HostIpReset = 32'h0A00_020F;
  localparam logic [15:0] EthTypeArp = 16'h0806;
  localparam logic [15:0] EthTypeIpv4 = 16'h0800;

  typedef enum logic [3:0] {
    VERDICT_RUNT       = 4'd0,
    VERDICT_UNKNOWN    = 4'd1,
    VERDICT_ARP_CACHED = 4'd2,
    VERDICT_ARP_REPLY  = 4'd3,
    VERDICT_ARP_IGNORE = 4'd4,
    VERDICT_IP_DROP    = 4'd5,
    VERDICT_ECHO       = 4'd6,
    VERDICT_IP_OTHER   = 4'd7,
    VERDICT_ICMP_BAD   = 4'd8,
    VERDICT_OVERSIZE   = 4'd9
  } verdict_t;

  // Frame summary handed from the parser to the judge
  typedef struct packed {
    logic [13:0] len;
    logic [15:0] ether_type;
    logic [7:0]  ver_ihl;
    logic [15:0] ip_tot_len;
    logic [15:0] frag;
    logic [7:0]  protocol;
    logic [15:0] hdr_sum;
    logic [15:0] icmp_sum;
    logic [39:0] icmp_fields;
    logic [63:0] arp0;
    logic [63:0] arp1;
  } frame_sum_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
  } result_t;

  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, s} + {1'b0, w};
    u = {1'b0, t[15:0]} + {16'd0, t[16]};
    return u[15:0];
  endfunction

endpackage

// ===== hdl/ethernet_arp_ipv4_icmp_rx_classifier.sv =====
// Top level: Ethernet ARP/IPv4/ICMP receive classifier.
// One byte is accepted per cycle, back to back, while the summary queue has room.
// After the last byte is taken its summary passes the parser register, a queue slot
// and the result register; one-byte frames give a verdict a cycle while results drain.
// The input stalls only once four verdicts wait behind a stalled result side.
// Synchronous active-high reset clears the parser, queue, result and ARP cache,
// and restores host_ip to its default of 0x0A00020F.
module ethernet_arp_ipv4_icmp_rx_classifier #(
  parameter int MaxFrame = earic_pkg::MaxFrameDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // frame_byte
  input  logic         s_axis_tlast,   // frame_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata    // verdict, peer_mac, peer_ip, echo_id, echo_seq
);

  logic [31:0] host_ip;
  logic p_valid, p_ready, q_valid, q_ready;
  earic_pkg::frame_sum_t p_data, q_data;
  earic_pkg::result_t res;

  // Hold the host address register
  always_ff @(posedge clk) begin
    if (rst) host_ip <= earic_pkg::HostIpReset;
    else if (cfg_wr_en) host_ip <= cfg_wr_data;
  end

  earic_parser #(.MaxFrame(MaxFrame)) u_parser (
    .clk, .rst, .byte_valid(s_axis_tvalid), .byte_ready(s_axis_tready),
    .frame_byte(s_axis_tdata), .frame_end(s_axis_tlast),
    .sum_valid(p_valid), .sum_ready(p_ready), .sum_data(p_data)
  );

  earic_queue u_queue (
    .clk, .rst, .in_valid(p_valid), .in_ready(p_ready), .in_data(p_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  earic_judge #(.MaxFrame(MaxFrame)) u_judge (
    .clk, .rst, .host_ip, .sum_valid(q_valid), .sum_ready(q_ready), .sum_data(q_data),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
  );

  assign m_axis_tdata = {4'd0, res.echo_seq, res.echo_id, res.peer_ip, res.peer_mac,
                         res.verdict};

endmodule

// ===== hdl/earic_parser.sv =====
// Front part: byte parser that captures header fields and running sums.
module earic_parser #(
  parameter int MaxFrame = earic_pkg::MaxFrameDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  logic [7:0]             frame_byte,
  input  logic                   frame_end,
  output logic                   sum_valid,
  input  logic                   sum_ready,
  output earic_pkg::frame_sum_t  sum_data
);

  earic_pkg::frame_sum_t cur;
  earic_pkg::frame_sum_t cur_next;
  logic [7:0] held_byte;
  logic [7:0] held_byte_next;
  logic take;

  assign byte_ready = !sum_valid || sum_ready;
  assign take = byte_valid && byte_ready;

  // Capture one byte into the running frame summary
  always_comb begin
    logic [13:0] pos;
    logic [13:0] rel;
    logic [13:0] hlen;
    logic [13:0] off;
    logic [15:0] word;
    cur_next = cur;
    held_byte_next = held_byte;
    pos = cur.len;
    rel = pos - 14'd14;
    hlen = 14'd0;
    off = 14'd0;
    word = {held_byte, frame_byte};
    if (pos < 14'(MaxFrame)) begin
      if (pos == 14'd12 || pos == 14'd13) begin
        cur_next.ether_type = {cur.ether_type[7:0], frame_byte};
      end else if (pos >= 14'd14) begin
        if (cur.ether_type == earic_pkg::EthTypeArp) begin
          if (pos >= 14'd20 && pos <= 14'd27)
            cur_next.arp0 = {cur.arp0[55:0], frame_byte};
          else if ((pos >= 14'd28 && pos <= 14'd31) || (pos >= 14'd38 && pos <= 14'd41))
            cur_next.arp1 = {cur.arp1[55:0], frame_byte};
        end else if (cur.ether_type == earic_pkg::EthTypeIpv4) begin
          if (rel == 14'd0) cur_next.ver_ihl = frame_byte;
          else if (rel == 14'd2 || rel == 14'd3)
            cur_next.ip_tot_len = {cur.ip_tot_len[7:0], frame_byte};
          else if (rel == 14'd6 || rel == 14'd7)
            cur_next.frag = {cur.frag[7:0], frame_byte};
          else if (rel == 14'd9) cur_next.protocol = frame_byte;
          hlen = {8'd0, cur_next.ver_ihl[3:0], 2'b00};
          off = rel - hlen;
          if (rel >= hlen && {2'b00, rel} < cur_next.ip_tot_len) begin
            if (off == 14'd0 || (off >= 14'd4 && off <= 14'd7))
              cur_next.icmp_fields = {cur.icmp_fields[31:0], frame_byte};
          end
          if (!rel[0]) begin
            held_byte_next = frame_byte;
            if (rel >= hlen && {2'b00, rel} + 16'd1 == cur_next.ip_tot_len)
              cur_next.icmp_sum = earic_pkg::oc_add(cur.icmp_sum, {frame_byte, 8'd0});
          end else if (rel < hlen) begin
            cur_next.hdr_sum = earic_pkg::oc_add(cur.hdr_sum, word);
          end else if ({2'b00, rel} < cur_next.ip_tot_len) begin
            cur_next.icmp_sum = earic_pkg::oc_add(cur.icmp_sum, word);
          end
        end
      end
    end
    if (pos <= 14'(MaxFrame)) cur_next.len = pos + 14'd1;
  end

  // Advance the summary, hand it over on the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      held_byte <= '0;
      sum_valid <= 1'b0;
    end else begin
      if (sum_valid && sum_ready) sum_valid <= 1'b0;
      if (take) begin
        if (frame_end) begin
          sum_data <= cur_next;
          sum_valid <= 1'b1;
          cur <= '0;
          held_byte <= '0;
        end else begin
          cur <= cur_next;
          held_byte <= held_byte_next;
        end
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    cur.len <= 14'(MaxFrame + 1)) else $error("byte count overran");
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    take && frame_end |=> cur.len == 14'd0) else $error("frame state not cleared");
  a_sum_held: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !sum_ready |=> sum_valid && $stable(sum_data)) else $error("summary lost");

endmodule

// ===== hdl/earic_queue.sv =====
// Short queue of frame summaries between parser and judge.
module earic_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  earic_pkg::frame_sum_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output earic_pkg::frame_sum_t out_data
);

  earic_pkg::frame_sum_t slot [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign in_ready = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data = slot[rd_ptr];

  // Push and pop requests
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        slot[wr_ptr] <= in_data;
        wr_ptr <= ~wr_ptr;
      end
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");
  a_full_ptr: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 || count == 2'd0 |-> wr_ptr == rd_ptr) else $error("pointer mismatch");
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd1 |-> wr_ptr != rd_ptr) else $error("pointer mismatch");

endmodule

// ===== hdl/earic_judge.sv =====
// Back part: verdict logic, ARP cache update and result register.
module earic_judge #(
  parameter int MaxFrame = earic_pkg::MaxFrameDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           host_ip,
  input  logic                  sum_valid,
  output logic                  sum_ready,
  input  earic_pkg::frame_sum_t sum_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output earic_pkg::result_t    res_data
);

  earic_pkg::result_t res;
  logic cache_wr;
  logic [31:0] cache_entry_ip;
  logic [47:0] cache_entry_mac;
  logic cache_entry_valid;
  logic take;

  assign sum_ready = !res_valid || res_ready;
  assign take = sum_valid && sum_ready;

  // Decide the verdict for one frame
  always_comb begin
    logic [15:0] oper;
    logic [47:0] mac;
    logic [31:0] spa;
    logic [31:0] tpa;
    logic [15:0] hlen;
    logic [15:0] tot;
    logic [15:0] len16;
    oper = sum_data.arp0[63:48];
    mac = sum_data.arp0[47:0];
    spa = sum_data.arp1[63:32];
    tpa = sum_data.arp1[31:0];
    hlen = {10'd0, sum_data.ver_ihl[3:0], 2'b00};
    tot = sum_data.ip_tot_len;
    len16 = {2'b00, sum_data.len};
    res = '0;
    cache_wr = 1'b0;
    if (sum_data.len > 14'(MaxFrame)) begin
      res.verdict = earic_pkg::VERDICT_OVERSIZE;
    end else if (sum_data.len < 14'd14) begin
      res.verdict = earic_pkg::VERDICT_RUNT;
    end else if (sum_data.ether_type == earic_pkg::EthTypeArp) begin
      if (sum_data.len < 14'd42 || tpa != host_ip || (oper != 16'd1 && oper != 16'd2)) begin
        res.verdict = earic_pkg::VERDICT_ARP_IGNORE;
      end else begin
        res.peer_mac = mac;
        res.peer_ip = spa;
        if (oper == 16'd2) begin
          res.verdict = earic_pkg::VERDICT_ARP_CACHED;
          cache_wr = 1'b1;
        end else begin
          res.verdict = earic_pkg::VERDICT_ARP_REPLY;
        end
      end
    end else if (sum_data.ether_type == earic_pkg::EthTypeIpv4) begin
      if (sum_data.len < 14'd34 || sum_data.ver_ihl[7:4] != 4'd4 || hlen < 16'd20 ||
          len16 < 16'd14 + hlen || tot < hlen || {1'b0, len16} < 17'd14 + {1'b0, tot} ||
          sum_data.frag[13:0] != 14'd0 || sum_data.hdr_sum != 16'hFFFF) begin
        res.verdict = earic_pkg::VERDICT_IP_DROP;
      end else if (sum_data.protocol != 8'd1) begin
        res.verdict = earic_pkg::VERDICT_IP_OTHER;
      end else if (tot - hlen < 16'd8 || sum_data.icmp_sum != 16'hFFFF) begin
        res.verdict = earic_pkg::VERDICT_ICMP_BAD;
      end else if (sum_data.icmp_fields[39:32] != 8'd0) begin
        res.verdict = earic_pkg::VERDICT_IP_OTHER;
      end else begin
        res.verdict = earic_pkg::VERDICT_ECHO;
        res.echo_id = sum_data.icmp_fields[31:16];
        res.echo_seq = sum_data.icmp_fields[15:0];
      end
    end else begin
      res.verdict = earic_pkg::VERDICT_UNKNOWN;
    end
  end

  // Register the result and refresh the cache
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      cache_entry_valid <= 1'b0;
      cache_entry_ip <= '0;
      cache_entry_mac <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (take) begin
        res_data <= res;
        res_valid <= 1'b1;
        if (cache_wr) begin
          cache_entry_ip <= res.peer_ip;
          cache_entry_mac <= res.peer_mac;
          cache_entry_valid <= 1'b1;
        end
      end
    end
  end

  a_cache_only_on_reply: assert property (@(posedge clk) disable iff (rst)
    cache_wr |-> res.verdict == earic_pkg::VERDICT_ARP_CACHED) else $error("bad cache write");
  a_res_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data)) else $error("result lost");
  a_cache_match: assert property (@(posedge clk) disable iff (rst)
    take && cache_wr |=> cache_entry_valid && cache_entry_ip == res_data.peer_ip &&
    cache_entry_mac == res_data.peer_mac) else $error("cache not refreshed");

endmodule
